>>> sv/ddsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddsr_pkg
// Shared widths, register indexes and reset values for the speed ramp block.
// ----------------------------------------------------------------------------
package ddsr_pkg;

   // field and register widths
   localparam int DDSR_SPD_W   = 16;
   localparam int DDSR_REG_W   = 16;
   localparam int DDSR_PWR_W   = 8;
   localparam int DDSR_IDX_W   = 3;

   // serial multiplier lane: signed multiplicand, unsigned multiplier
   localparam int DDSR_MCAND_W = 34;
   localparam int DDSR_MPLR_W  = 16;
   localparam int DDSR_PROD_W  = DDSR_MCAND_W + DDSR_MPLR_W + 1;

   // fixed point: Q.36 wheel and Q.24 power both drop 24 fraction bits
   localparam int DDSR_FRAC_SH = 24;
   localparam int DDSR_PSUM_W  = 44;

   localparam int DDSR_POWER_MAX = 80;
   localparam int DDSR_POWER_MIN = -100;

   // register indexes
   localparam logic [DDSR_IDX_W-1:0] CSR_GAIN_LEFT      = 3'd0;
   localparam logic [DDSR_IDX_W-1:0] CSR_GAIN_RIGHT     = 3'd1;
   localparam logic [DDSR_IDX_W-1:0] CSR_OFFSET_LEFT    = 3'd2;
   localparam logic [DDSR_IDX_W-1:0] CSR_OFFSET_RIGHT   = 3'd3;
   localparam logic [DDSR_IDX_W-1:0] CSR_HALF_TRACK     = 3'd4;
   localparam logic [DDSR_IDX_W-1:0] CSR_INVERSE_RADIUS = 3'd5;

   // register reset values
   localparam logic [DDSR_REG_W-1:0] RST_GAIN_LEFT      = 16'd22566;
   localparam logic [DDSR_REG_W-1:0] RST_GAIN_RIGHT     = 16'd22551;
   localparam logic [DDSR_REG_W-1:0] RST_OFFSET_LEFT    = 16'd7483;
   localparam logic [DDSR_REG_W-1:0] RST_OFFSET_RIGHT   = 16'd10845;
   localparam logic [DDSR_REG_W-1:0] RST_HALF_TRACK     = 16'd4260;
   localparam logic [DDSR_REG_W-1:0] RST_INVERSE_RADIUS = 16'd9143;

endpackage

>>> sv/diff_drive_speed_ramp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_speed_ramp
// Speed ramp and per-motor power for a differential-drive robot.
//
// A request on req_ carries target and step for linear and angular speed.
// The block ramps its two stored speeds, works out both wheel speeds and a
// linear power per motor, limits the powers and returns one response on
// rsp_ with the powers, the in-limit flag and the new speeds. The user is to
// write registers on the csr_ port only while idle; it is not enforced.
//
// The block takes one request at a time, as req_tready is high only in the
// idle state. A load state starts the sequence, then three passes (a load and
// 16 bit steps) run on two bit-serial multiplier lanes (half track by angular
// speed, sums by inverse radius, wheel speed by gain), then a power sum and a
// limit. A finished response waits in the output register; the next request
// is accepted meanwhile, and work halts at the limit step until the output
// register is free. Reset clears the stored speeds to zero, restores the
// register defaults and empties the output register.
// ----------------------------------------------------------------------------
module diff_drive_speed_ramp
   import ddsr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request: target_v[15:0], target_w[31:16], step_v[47:32], step_w[63:48]
   input  logic [63:0]           req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // response: left_power[7:0], right_power[15:8], within_limit[16],
   //           speed_v_now[32:17], speed_w_now[48:33], zero[55:49]
   output logic [55:0]           rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // register writes
   input  logic                  csr_we,
   input  logic [DDSR_IDX_W-1:0] csr_index,
   input  logic [DDSR_REG_W-1:0] csr_wdata
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOAD  = 3'd1;
   localparam logic [2:0] ST_MUL_S = 3'd2;
   localparam logic [2:0] ST_MUL_W = 3'd3;
   localparam logic [2:0] ST_MUL_P = 3'd4;
   localparam logic [2:0] ST_POWER = 3'd5;
   localparam logic [2:0] ST_FINAL = 3'd6;

   localparam logic signed [DDSR_PSUM_W-1:0] POWER_LIM =
      DDSR_PSUM_W'(DDSR_POWER_MAX) <<< DDSR_FRAC_SH;
   localparam int QW = DDSR_PSUM_W - DDSR_FRAC_SH;
   localparam int WW = DDSR_PROD_W - DDSR_FRAC_SH;

   // configuration registers
   logic [DDSR_REG_W-1:0] gain_l_ff, gain_r_ff, half_track_ff, inv_radius_ff;
   logic signed [DDSR_REG_W-1:0] offset_l_ff, offset_r_ff;

   logic [2:0] state_ff, state_in;
   logic       req_fire, rsp_load;

   logic signed [DDSR_SPD_W-1:0] speed_v, speed_w;

   logic                           lane_start;
   logic                           done0, done1;
   logic signed [DDSR_MCAND_W-1:0] mcand0, mcand1;
   logic        [DDSR_MPLR_W-1:0]  mplr0, mplr1;
   logic signed [DDSR_PROD_W-1:0]  prod0, prod1;

   logic signed [DDSR_MCAND_W-1:0] spin, sum_r, sum_l, vshift;
   logic signed [DDSR_MCAND_W-1:0] wheel_r, wheel_l;

   logic signed [DDSR_PSUM_W-1:0] psum_r_ff, psum_r_in, psum_l_ff, psum_l_in;
   logic signed [DDSR_PSUM_W-1:0] off_r_ext, off_l_ext;

   logic                         over, zero_speed;
   logic signed [DDSR_PWR_W-1:0] pwr_l, pwr_r;
   logic                         in_limit;

   logic [55:0] rsp_data_ff, rsp_data_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // truncate a Q.36 wheel product toward zero to Q.12
   function automatic logic signed [DDSR_MCAND_W-1:0] wheel_trunc(
      input logic signed [DDSR_PROD_W-1:0] p
   );
      logic signed [WW-1:0] q;
      q = p[DDSR_PROD_W-1:DDSR_FRAC_SH];
      if (p[DDSR_PROD_W-1] && (p[DDSR_FRAC_SH-1:0] != '0))
         q = q + WW'(1);
      return DDSR_MCAND_W'(q);
   endfunction

   // truncate a Q.24 power toward zero, floor it at the minimum
   function automatic logic signed [DDSR_PWR_W-1:0] power_trunc(
      input logic signed [DDSR_PSUM_W-1:0] p
   );
      logic signed [QW-1:0] q;
      q = p[DDSR_PSUM_W-1:DDSR_FRAC_SH];
      if (p[DDSR_PSUM_W-1] && (p[DDSR_FRAC_SH-1:0] != '0))
         q = q + QW'(1);
      if (q < QW'(DDSR_POWER_MIN))
         q = QW'(DDSR_POWER_MIN);
      return q[DDSR_PWR_W-1:0];
   endfunction

   // register writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_l_ff     <= RST_GAIN_LEFT;
         gain_r_ff     <= RST_GAIN_RIGHT;
         offset_l_ff   <= RST_OFFSET_LEFT;
         offset_r_ff   <= RST_OFFSET_RIGHT;
         half_track_ff <= RST_HALF_TRACK;
         inv_radius_ff <= RST_INVERSE_RADIUS;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GAIN_LEFT:      gain_l_ff     <= csr_wdata;
            CSR_GAIN_RIGHT:     gain_r_ff     <= csr_wdata;
            CSR_OFFSET_LEFT:    offset_l_ff   <= csr_wdata;
            CSR_OFFSET_RIGHT:   offset_r_ff   <= csr_wdata;
            CSR_HALF_TRACK:     half_track_ff <= csr_wdata;
            CSR_INVERSE_RADIUS: inv_radius_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   ddsr_ramp u_ramp (
      .clock    (clock),
      .reset    (reset),
      .update   (req_fire),
      .target_v (req_tdata[15:0]),
      .target_w (req_tdata[31:16]),
      .step_v   (req_tdata[47:32]),
      .step_w   (req_tdata[63:48]),
      .speed_v  (speed_v),
      .speed_w  (speed_w)
   );

   // wheel sums from the half-track product
   assign spin   = prod0[DDSR_MCAND_W-1:0];
   assign vshift = {{(DDSR_MCAND_W-DDSR_SPD_W-16){speed_v[DDSR_SPD_W-1]}}, speed_v, 16'b0};
   assign sum_r  = vshift + spin;
   assign sum_l  = vshift - spin;

   assign wheel_r = wheel_trunc(prod0);
   assign wheel_l = wheel_trunc(prod1);

   // start both lanes in the load state and after each of the first two passes
   assign lane_start = (state_ff == ST_LOAD) ||
                       (done0 && (state_ff == ST_MUL_S || state_ff == ST_MUL_W));

   // lane 0 carries the right side, lane 1 the left
   always_comb begin
      mcand0 = wheel_r;
      mcand1 = wheel_l;
      mplr0  = gain_r_ff;
      mplr1  = gain_l_ff;
      case (state_ff)
         ST_LOAD: begin
            mcand0 = DDSR_MCAND_W'(speed_w);
            mcand1 = DDSR_MCAND_W'(speed_w);
            mplr0  = half_track_ff;
            mplr1  = half_track_ff;
         end
         ST_MUL_S: begin
            mcand0 = sum_r;
            mcand1 = sum_l;
            mplr0  = inv_radius_ff;
            mplr1  = inv_radius_ff;
         end
         default: ;
      endcase
   end

   ddsr_mul_lane #(
      .MCAND_W (DDSR_MCAND_W),
      .MPLR_W  (DDSR_MPLR_W)
   ) u_lane0 (
      .clock   (clock),
      .reset   (reset),
      .start   (lane_start),
      .mcand   (mcand0),
      .mplr    (mplr0),
      .done    (done0),
      .product (prod0)
   );

   ddsr_mul_lane #(
      .MCAND_W (DDSR_MCAND_W),
      .MPLR_W  (DDSR_MPLR_W)
   ) u_lane1 (
      .clock   (clock),
      .reset   (reset),
      .start   (lane_start),
      .mcand   (mcand1),
      .mplr    (mplr1),
      .done    (done1),
      .product (prod1)
   );

   // add the offsets to the gain products
   assign off_r_ext = {{(DDSR_PSUM_W-DDSR_REG_W-12){offset_r_ff[DDSR_REG_W-1]}},
                       offset_r_ff, 12'b0};
   assign off_l_ext = {{(DDSR_PSUM_W-DDSR_REG_W-12){offset_l_ff[DDSR_REG_W-1]}},
                       offset_l_ff, 12'b0};
   assign psum_r_in = (state_ff == ST_POWER) ? prod0[DDSR_PSUM_W-1:0] + off_r_ext
                                             : psum_r_ff;
   assign psum_l_in = (state_ff == ST_POWER) ? prod1[DDSR_PSUM_W-1:0] + off_l_ext
                                             : psum_l_ff;

   always_ff @(posedge clock) begin
      psum_r_ff <= psum_r_in;
      psum_l_ff <= psum_l_in;
   end

   // limit the powers; both speeds zero gives zero power
   assign zero_speed = (speed_v == '0) && (speed_w == '0);
   assign over       = !zero_speed && ((psum_l_ff > POWER_LIM) || (psum_r_ff > POWER_LIM));

   always_comb begin
      in_limit = 1'b1;
      pwr_l    = '0;
      pwr_r    = '0;
      if (zero_speed) begin
         pwr_l = '0;
         pwr_r = '0;
      end else if (over) begin
         in_limit = 1'b0;
         pwr_l    = DDSR_PWR_W'(DDSR_POWER_MAX);
         pwr_r    = DDSR_PWR_W'(DDSR_POWER_MAX);
      end else begin
         pwr_l = power_trunc(psum_l_ff);
         pwr_r = power_trunc(psum_r_ff);
      end
   end

   // output register: load at the limit step once free
   assign rsp_load    = (state_ff == ST_FINAL) && (!rsp_valid_ff || rsp_tready);
   assign rsp_data_in = rsp_load ? {7'b0, speed_w, speed_v, in_limit, pwr_r, pwr_l}
                                 : rsp_data_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load)
         rsp_valid_in = 1'b1;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_fire) state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_MUL_S;
         ST_MUL_S: if (done0) state_in = ST_MUL_W;
         ST_MUL_W: if (done0) state_in = ST_MUL_P;
         ST_MUL_P: if (done0) state_in = ST_POWER;
         ST_POWER: state_in = ST_FINAL;
         ST_FINAL: if (rsp_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      done0 == done1)
      else $error("multiplier lanes out of step");
   a_done_in_pass: assert property (@(posedge clock) disable iff (reset)
      done0 |-> (state_ff == ST_MUL_S || state_ff == ST_MUL_W ||
                 state_ff == ST_MUL_P))
      else $error("multiplier pass finished outside a multiply state");
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_LOAD)
      else $error("accepted request did not start the sequence");
   a_rsp_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINAL)
      else $error("response raised outside the limit step");
`endif

endmodule

>>> sv/ddsr_mul_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddsr_mul_lane
// Bit-serial shift-add multiplier: one multiplier bit per cycle, product
// low bits shift in behind the multiplier bits.
// ----------------------------------------------------------------------------
module ddsr_mul_lane
   import ddsr_pkg::*;
#(
   parameter int MCAND_W = DDSR_MCAND_W,
   parameter int MPLR_W  = DDSR_MPLR_W
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [MCAND_W-1:0]     mcand,
   input  logic        [MPLR_W-1:0]      mplr,
   output logic                          done,
   output logic signed [MCAND_W+MPLR_W:0] product
);

   localparam int CNT_W = (MPLR_W > 1) ? $clog2(MPLR_W) : 1;

   logic signed [MCAND_W-1:0] mcand_ff, mcand_in;
   logic signed [MCAND_W:0]   hi_ff, hi_in, hi_sum;
   logic        [MPLR_W-1:0]  lo_ff, lo_in;
   logic        [CNT_W-1:0]   cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic                      last;

   assign last = (cnt_ff == CNT_W'(MPLR_W - 1));

   // add the multiplicand when the current multiplier bit is set
   assign hi_sum = hi_ff + (lo_ff[0] ? {mcand_ff[MCAND_W-1], mcand_ff}
                                     : {(MCAND_W+1){1'b0}});

   always_comb begin
      mcand_in = mcand_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         // load operands, clear the running sum
         mcand_in = mcand;
         hi_in    = '0;
         lo_in    = mplr;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // shift the pair right by one bit
         hi_in  = {hi_sum[MCAND_W], hi_sum[MCAND_W:1]};
         lo_in  = {hi_sum[0], lo_ff[MPLR_W-1:1]};
         cnt_in = cnt_ff + CNT_W'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("multiplier lane restarted while busy");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("multiplier lane done while still busy");
   a_count_fresh: assert property (@(posedge clock) disable iff (reset)
      $rose(busy_ff) |-> cnt_ff == '0)
      else $error("multiplier lane started with a stale bit count");
`endif

endmodule

>>> sv/ddsr_ramp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddsr_ramp
// Holds the current linear and angular speeds and steps them toward their
// targets once per request, or sets them to the target if the step is not positive.
// ----------------------------------------------------------------------------
module ddsr_ramp
   import ddsr_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         update,
   input  logic signed [DDSR_SPD_W-1:0] target_v,
   input  logic signed [DDSR_SPD_W-1:0] target_w,
   input  logic signed [DDSR_SPD_W-1:0] step_v,
   input  logic signed [DDSR_SPD_W-1:0] step_w,
   output logic signed [DDSR_SPD_W-1:0] speed_v,
   output logic signed [DDSR_SPD_W-1:0] speed_w
);

   localparam logic signed [DDSR_SPD_W:0] SAT_HI = (DDSR_SPD_W+1)'(2**(DDSR_SPD_W-1) - 1);
   localparam logic signed [DDSR_SPD_W:0] SAT_LO = -(DDSR_SPD_W+1)'(2**(DDSR_SPD_W-1));

   logic signed [DDSR_SPD_W-1:0] cur_v_ff, cur_v_in, cur_w_ff, cur_w_in;

   // one speed: jump, step up or step down with saturation
   function automatic logic signed [DDSR_SPD_W-1:0] ramp_one(
      input logic signed [DDSR_SPD_W-1:0] cur,
      input logic signed [DDSR_SPD_W-1:0] tgt,
      input logic signed [DDSR_SPD_W-1:0] stp
   );
      logic signed [DDSR_SPD_W:0] nxt;
      logic signed [DDSR_SPD_W-1:0] res;
      if (tgt > cur)
         nxt = {cur[DDSR_SPD_W-1], cur} + {stp[DDSR_SPD_W-1], stp};
      else
         nxt = {cur[DDSR_SPD_W-1], cur} - {stp[DDSR_SPD_W-1], stp};
      if (cur == tgt)
         res = cur;
      else if (stp <= 0)
         res = tgt;
      else if (nxt > SAT_HI)
         res = SAT_HI[DDSR_SPD_W-1:0];
      else if (nxt < SAT_LO)
         res = SAT_LO[DDSR_SPD_W-1:0];
      else
         res = nxt[DDSR_SPD_W-1:0];
      return res;
   endfunction

   assign cur_v_in = update ? ramp_one(cur_v_ff, target_v, step_v) : cur_v_ff;
   assign cur_w_in = update ? ramp_one(cur_w_ff, target_w, step_w) : cur_w_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_v_ff <= '0;
         cur_w_ff <= '0;
      end else begin
         cur_v_ff <= cur_v_in;
         cur_w_ff <= cur_w_in;
      end
   end

   assign speed_v = cur_v_ff;
   assign speed_w = cur_w_ff;

endmodule
